// ===== hdl/dwcs_pkg.sv =====
package dwcs_pkg;

   // field widths of the stream payloads
   localparam int COORD_W    = 24;
   localparam int REQ_DATA_W = 4 * COORD_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 3 * COORD_W;
   localparam int RSP_USER_W = 2;

   // default sizing of the accumulators
   localparam int MAX_POINTS_DEF = 4096;
   localparam int SUM_W_DEF      = 2 * COORD_W + $clog2(MAX_POINTS_DEF);
   localparam int TOT_W_DEF      = COORD_W + $clog2(MAX_POINTS_DEF);

   // command carried in req_tuser
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ACCUM  = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_SHIFT  = 2'd3
   } cmd_type;

   // result kind carried in rsp_tuser[0]
   typedef enum logic {
      KIND_CENTER = 1'b0,
      KIND_SHIFT  = 1'b1
   } kind_type;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load_in;
      logic       sum_clr;
      logic       sum_acc;
      logic       div_start;
      logic       div_step;
      logic       div_store;
      logic       zero_center;
      logic       out_load;
      kind_type   out_kind;
      logic [1:0] axis;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tot_zero;
      logic div_done;
      logic out_free;
   } ctl_stat_type;

endpackage

// ===== hdl/dwcs_ctrl.sv =====
module dwcs_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [dwcs_pkg::REQ_USER_W-1:0]        req_tuser,
   input  dwcs_pkg::ctl_stat_type                 stat,
   output dwcs_pkg::ctl_cmd_type                  cmd
);
   import dwcs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ACC   = 6'b000010,
      ST_FIN   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_STORE = 6'b010000,
      ST_SEND  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   kind_type   kind_ff, kind_in;
   cmd_type    req_cmd;

   assign req_cmd = cmd_type'(req_tuser);

   // next state and command decode
   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      kind_in    = kind_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.axis   = axis_ff;
      cmd.out_kind = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               axis_in     = AXIS_X;
               unique case (req_cmd)
                  CMD_CLEAR:  cmd.sum_clr = 1'b1;
                  CMD_ACCUM:  state_in = ST_ACC;
                  CMD_FINISH: begin
                     kind_in  = KIND_CENTER;
                     state_in = ST_FIN;
                  end
                  CMD_SHIFT: begin
                     kind_in  = KIND_SHIFT;
                     state_in = ST_SEND;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_FIN: begin
            if (stat.tot_zero) begin
               cmd.zero_center = 1'b1;
               state_in        = ST_SEND;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.div_store = 1'b1;
            if (axis_ff == AXIS_Z) begin
               state_in = ST_SEND;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_FIN;
            end
         end
         ST_SEND: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_X;
         kind_ff  <= KIND_CENTER;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== hdl/dwcs_datapath.sv =====
module dwcs_datapath #(
   parameter int SUM_W = dwcs_pkg::SUM_W_DEF,
   parameter int TOT_W = dwcs_pkg::TOT_W_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [dwcs_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dwcs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [dwcs_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  dwcs_pkg::ctl_cmd_type                  cmd,
   output dwcs_pkg::ctl_stat_type                 stat
);
   import dwcs_pkg::*;

   localparam int PROD_W = 2 * COORD_W;
   localparam int CNT_W  = $clog2(SUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);
   localparam logic [SUM_W-1:0] MAG_POS_LIM = SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
   localparam logic [SUM_W-1:0] MAG_NEG_LIM = SUM_W'(64'd1 << (COORD_W - 1));
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // latched point and registered products
   logic signed [COORD_W-1:0] pos_ff [3];
   logic signed [COORD_W-1:0] pos_in [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [COORD_W-1:0] wgt_ff;
   logic signed [COORD_W-1:0] wgt_in;

   // running sums, center and flag
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic signed [TOT_W-1:0]   tot_ff;
   logic signed [COORD_W-1:0] center_ff [3];
   logic                      tz_ff;

   // shared restoring divider
   logic [TOT_W:0]            rem_ff;
   logic [SUM_W-1:0]          quo_ff;
   logic [TOT_W-1:0]          dvsr_ff;
   logic                      neg_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [SUM_W-1:0]          num_sel;
   logic [SUM_W-1:0]          num_mag;
   logic [TOT_W-1:0]          tot_mag;
   logic [TOT_W:0]            rem_shift;
   logic [TOT_W:0]            rem_diff;
   logic                      rem_ge;
   logic signed [COORD_W-1:0] quo_sat;

   // output register
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic [RSP_USER_W-1:0]     rsp_user_ff;
   logic signed [COORD_W-1:0] shift_val [3];
   logic signed [COORD_W:0]   shift_diff [3];

   // input split and products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_in[i]  = req_tdata[i*COORD_W +: COORD_W];
      end
      wgt_in = req_tdata[3*COORD_W +: COORD_W];
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = pos_in[i] * wgt_in;
      end
   end

   // divider operand magnitudes and one quotient bit per step
   assign num_sel   = sum_ff[cmd.axis];
   assign num_mag   = num_sel[SUM_W-1] ? (~num_sel + SUM_W'(1)) : num_sel;
   assign tot_mag   = tot_ff[TOT_W-1] ? (~tot_ff + TOT_W'(1)) : tot_ff;
   assign rem_shift = {rem_ff[TOT_W-1:0], quo_ff[SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvsr_ff};
   assign rem_ge    = (rem_shift >= {1'b0, dvsr_ff});

   // signed quotient, saturated to the coordinate range
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > MAG_NEG_LIM) begin
            quo_sat = COORD_MIN;
         end else begin
            quo_sat = -$signed(quo_ff[COORD_W-1:0]);
         end
      end else begin
         if (quo_ff > MAG_POS_LIM) begin
            quo_sat = COORD_MAX;
         end else begin
            quo_sat = $signed(quo_ff[COORD_W-1:0]);
         end
      end
   end

   // point minus center, saturated
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shift_diff[i] = {pos_ff[i][COORD_W-1], pos_ff[i]}
                       - {center_ff[i][COORD_W-1], center_ff[i]};
         if (shift_diff[i][COORD_W] != shift_diff[i][COORD_W-1]) begin
            shift_val[i] = shift_diff[i][COORD_W] ? COORD_MIN : COORD_MAX;
         end else begin
            shift_val[i] = shift_diff[i][COORD_W-1:0];
         end
      end
   end

   // input latch and products (payload)
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         pos_ff  <= pos_in;
         prod_ff <= prod_in;
         wgt_ff  <= wgt_in;
      end
   end

   // accumulators, center and flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]    <= '0;
            center_ff[i] <= '0;
         end
         tot_ff <= '0;
         tz_ff  <= 1'b0;
      end else begin
         if (cmd.sum_clr) begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= '0;
            end
            tot_ff <= '0;
         end else if (cmd.sum_acc) begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(prod_ff[i]);
            end
            tot_ff <= tot_ff + TOT_W'(wgt_ff);
         end
         if (cmd.zero_center) begin
            for (int i = 0; i < 3; i++) begin
               center_ff[i] <= '0;
            end
            tz_ff <= 1'b1;
         end else if (cmd.div_start) begin
            tz_ff <= 1'b0;
         end
         if (cmd.div_store) begin
            center_ff[cmd.axis] <= quo_sat;
         end
      end
   end

   // divider registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= '0;
         quo_ff  <= num_mag;
         dvsr_ff <= tot_mag;
         neg_ff  <= num_sel[SUM_W-1] ^ tot_ff[TOT_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_diff : rem_shift;
         quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_kind == KIND_SHIFT) begin
            rsp_data_ff <= {shift_val[2], shift_val[1], shift_val[0]};
         end else begin
            rsp_data_ff <= {center_ff[2], center_ff[1], center_ff[0]};
         end
         rsp_user_ff <= {tz_ff, cmd.out_kind};
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_tuser     = rsp_user_ff;
   assign stat.tot_zero = (tot_ff == '0);
   assign stat.div_done = (cnt_ff == CNT_LAST);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

endmodule

// ===== hdl/density_weighted_centroid_shift.sv =====
// Density-weighted center of mass of a 3D point cloud in signed Q15.8. Send
// clear, then accumulate every point (x*w, y*w, z*w and w are summed), then
// finish to get the center (sum / total per axis, truncated toward zero and
// saturated; a zero total gives a zero center with zero_total set), then
// shift every point to get it minus the center, saturated. Items are handled
// one at a time by a controller and a datapath. Finish runs the one shared
// restoring divider, which produces one quotient bit per cycle for each of
// the three axes in turn; a finish with a zero total skips the divider. The
// result sits in an output register, so the next item is taken while a
// result waits for rsp_tready. MAX_POINTS sizes the sums; accumulating more
// points wraps them.
module density_weighted_centroid_shift #(
   parameter int MAX_POINTS = dwcs_pkg::MAX_POINTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // pos_x, pos_y, pos_z, weight
   input  logic [dwcs_pkg::REQ_DATA_W-1:0]        req_tdata,
   // command
   input  logic [dwcs_pkg::REQ_USER_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_x, out_y, out_z
   output logic [dwcs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // kind, zero_total
   output logic [dwcs_pkg::RSP_USER_W-1:0]        rsp_tuser
);
   import dwcs_pkg::*;

   localparam int SUM_W = 2 * COORD_W + $clog2(MAX_POINTS);
   localparam int TOT_W = COORD_W + $clog2(MAX_POINTS);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   dwcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   dwcs_datapath #(
      .SUM_W (SUM_W),
      .TOT_W (TOT_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

`ifndef SYNTHESIS
   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result register loaded while a result is still pending");

   // the divider only runs on a nonzero total
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !stat.tot_zero)
      else $error("divider stepping with a zero total");

   // no input transfer while the divider is busy
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_tready)
      else $error("input taken during a division");

   // a center is only stored at the end of a full division
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> $past(cmd.div_step) && $past(stat.div_done))
      else $error("center stored before the division finished");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dwcs_pkg::*;

   localparam logic [COORD_W-1:0] COORD_MAX_V = 24'h7FFFFF;
   localparam logic [COORD_W-1:0] COORD_MIN_V = 24'h800000;
   localparam int RANDOM_ITEMS = 700;
   localparam int WRAP_POINTS  = 200;    // long accumulate run at extreme values
   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int REPORT_MAX   = 10;

   // one result as the block should emit it
   typedef struct packed {
      kind_type                  kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      zero_total;
   } point_result_type;

   // tracks the weighted sums and the center, queues the results they imply
   class centroid_tracker;
      logic signed [SUM_W_DEF-1:0] sum_wx, sum_wy, sum_wz;
      logic signed [TOT_W_DEF-1:0] total_weight;
      logic signed [COORD_W-1:0]   center_x, center_y, center_z;
      logic                        zero_flag;
      point_result_type            expected_q[$];
      int                          mismatches;

      function new();
         sum_wx       = '0;
         sum_wy       = '0;
         sum_wz       = '0;
         total_weight = '0;
         center_x     = '0;
         center_y     = '0;
         center_z     = '0;
         zero_flag    = 1'b0;
         mismatches   = 0;
      endfunction

      function logic signed [COORD_W-1:0] clamp(longint v);
         if (v > longint'(8388607))
            return COORD_MAX_V;
         if (v < -longint'(8388608))
            return COORD_MIN_V;
         return v[COORD_W-1:0];
      endfunction

      function void take_command(cmd_type cmd, logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y,
                                 logic signed [COORD_W-1:0] z,
                                 logic signed [COORD_W-1:0] w);
         longint           tot;
         point_result_type r;
         case (cmd)
            CMD_CLEAR: begin
               sum_wx       = '0;
               sum_wy       = '0;
               sum_wz       = '0;
               total_weight = '0;
            end
            CMD_ACCUM: begin
               // sums wrap at their own width
               sum_wx       = sum_wx + longint'(x) * longint'(w);
               sum_wy       = sum_wy + longint'(y) * longint'(w);
               sum_wz       = sum_wz + longint'(z) * longint'(w);
               total_weight = total_weight + longint'(w);
            end
            CMD_FINISH: begin
               tot = longint'(total_weight);
               if (tot == 0) begin
                  center_x  = '0;
                  center_y  = '0;
                  center_z  = '0;
                  zero_flag = 1'b1;
               end else begin
                  // signed divide truncates toward zero
                  center_x  = clamp(longint'(sum_wx) / tot);
                  center_y  = clamp(longint'(sum_wy) / tot);
                  center_z  = clamp(longint'(sum_wz) / tot);
                  zero_flag = 1'b0;
               end
               r.kind       = KIND_CENTER;
               r.x          = center_x;
               r.y          = center_y;
               r.z          = center_z;
               r.zero_total = zero_flag;
               expected_q   = {expected_q, r};
            end
            default: begin
               r.kind       = KIND_SHIFT;
               r.x          = clamp(longint'(x) - longint'(center_x));
               r.y          = clamp(longint'(y) - longint'(center_y));
               r.z          = clamp(longint'(z) - longint'(center_z));
               r.zero_total = zero_flag;
               expected_q   = {expected_q, r};
            end
         endcase
      endfunction

      function void compare_result(logic [RSP_DATA_W-1:0] data,
                                   logic [RSP_USER_W-1:0] user);
         point_result_type got;
         point_result_type exp_r;
         got.kind       = kind_type'(user[0]);
         got.zero_total = user[1];
         got.x          = data[COORD_W-1:0];
         got.y          = data[2*COORD_W-1:COORD_W];
         got.z          = data[3*COORD_W-1:2*COORD_W];
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: kind %0d xyz %0d %0d %0d zero_total %0d",
                        got.kind, got.x, got.y, got.z, got.zero_total);
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.kind != exp_r.kind || got.x != exp_r.x || got.y != exp_r.y ||
             got.z != exp_r.z || got.zero_total != exp_r.zero_total) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("mismatch: expected kind %0d xyz %0d %0d %0d zero_total %0d",
                        exp_r.kind, exp_r.x, exp_r.y, exp_r.z, exp_r.zero_total);
               $display("          actual   kind %0d xyz %0d %0d %0d zero_total %0d",
                        got.kind, got.x, got.y, got.z, got.zero_total);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // pos_x, pos_y, pos_z, weight
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // out_x, out_y, out_z
   logic [RSP_USER_W-1:0] rsp_tuser;         // kind, zero_total

   centroid_tracker tracker = new();
   int  items_sent  = 0;
   int  cycles      = 0;
   int  ready_hold  = 0;
   int  ready_pick;
   bit  steady_feed = 1'b0;

   density_weighted_centroid_shift uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle count and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // stall lengths: mostly short, now and then long
   function automatic int stall_len();
      if ($urandom_range(0, 9) < 7)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic int feed_gap();
      if (steady_feed)
         return 0;
      if ($urandom_range(0, 99) < 55)
         return 0;
      return stall_len();
   endfunction

   function automatic logic [COORD_W-1:0] fx(int v);
      return v[COORD_W-1:0];
   endfunction

   // extremes, zero, small values and full-range values
   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MAX_V;
         1:       return COORD_MIN_V;
         2:       return '0;
         3, 4:    return fx(int'($urandom_range(0, 4095)) - 2048);
         default: return COORD_W'($urandom());
      endcase
   endfunction

   // result side back-pressure, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 10) begin
            rsp_tready <= 1'b1;
            ready_hold <= 300;
         end else if (ready_pick < 55) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= stall_len();
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.compare_result(rsp_tdata, rsp_tuser);
   end

   // one input transfer, after an optional idle gap
   task automatic send_item(cmd_type cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic [COORD_W-1:0] w);
      int gap;
      gap = feed_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {w, z, y, x};
      do @(posedge clock); while (!req_tready);
      tracker.take_command(cmd, x, y, z, w);
      items_sent++;
   endtask

   task automatic send_random(cmd_type cmd);
      send_item(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   // hold the input side until every expected result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // clear, a set of points, finish, then shifted points
   task automatic run_frame();
      int                        npts;
      int                        nshift;
      int                        style;
      logic signed [COORD_W-1:0] w;
      npts   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      nshift = $urandom_range(0, 12);
      style  = $urandom_range(0, 9);
      send_random(CMD_CLEAR);
      for (int i = 0; i < npts; i++) begin
         if (style == 0) begin
            // all weights zero
            send_item(CMD_ACCUM, rand_coord(), rand_coord(), rand_coord(), '0);
         end else if (style == 1) begin
            // weights cancel in pairs, so the total ends up zero unless a weight is the most negative value
            w = rand_coord();
            send_item(CMD_ACCUM, rand_coord(), rand_coord(), rand_coord(), w);
            send_item(CMD_ACCUM, rand_coord(), rand_coord(), rand_coord(), -w);
         end else begin
            send_random(CMD_ACCUM);
         end
      end
      send_random(CMD_FINISH);
      for (int i = 0; i < nshift; i++)
         send_random(CMD_SHIFT);
   endtask

   initial begin
      int target;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: shift before any finish, then finish on an empty set
      send_item(CMD_SHIFT, COORD_MAX_V, COORD_MIN_V, '0, COORD_MAX_V);
      send_item(CMD_FINISH, '0, '0, '0, '0);
      send_item(CMD_SHIFT, COORD_MIN_V, COORD_MAX_V, fx(-1), '0);
      // center at the top, shift from the bottom saturates low
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      send_item(CMD_ACCUM, COORD_MAX_V, COORD_MAX_V, COORD_MAX_V, fx(1));
      send_item(CMD_FINISH, '0, '0, '0, '0);
      send_item(CMD_SHIFT, COORD_MIN_V, COORD_MIN_V, COORD_MIN_V, '0);
      // center at the bottom; clear keeps it; shift from the top saturates high
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      send_item(CMD_ACCUM, COORD_MIN_V, COORD_MIN_V, COORD_MIN_V, fx(1));
      send_item(CMD_FINISH, '0, '0, '0, '0);
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      send_item(CMD_SHIFT, COORD_MAX_V, COORD_MAX_V, COORD_MAX_V, '0);
      // quotient beyond range in both directions
      send_item(CMD_ACCUM, COORD_MAX_V, COORD_MIN_V, COORD_MAX_V, fx(2));
      send_item(CMD_ACCUM, COORD_MIN_V, COORD_MAX_V, '0, fx(-1));
      send_item(CMD_FINISH, '0, '0, '0, '0);
      // extreme weights, total of minus one
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      send_item(CMD_ACCUM, COORD_MIN_V, COORD_MIN_V, COORD_MIN_V, COORD_MIN_V);
      send_item(CMD_ACCUM, COORD_MAX_V, COORD_MAX_V, COORD_MAX_V, COORD_MAX_V);
      send_item(CMD_FINISH, '0, '0, '0, '0);
      // truncation toward zero on odd quotients
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      send_item(CMD_ACCUM, fx(5), fx(-5), fx(7), fx(1));
      send_item(CMD_ACCUM, '0, '0, '0, fx(1));
      send_item(CMD_FINISH, '0, '0, '0, '0);
      send_item(CMD_SHIFT, fx(100), fx(-100), '0, '0);
      wait_drained();

      // random: mostly well-formed frames, some loose commands
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         steady_feed = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 85) begin
            run_frame();
         end else begin
            repeat ($urandom_range(1, 8))
               send_random(cmd_type'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 19) == 0)
            wait_drained();
      end
      wait_drained();

      // long back-to-back run of extreme points: sums grow large
      steady_feed = 1'b1;
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      for (int i = 0; i < WRAP_POINTS; i++)
         send_item(CMD_ACCUM, COORD_MIN_V, COORD_MAX_V, rand_coord(), COORD_MIN_V);
      steady_feed = 1'b0;
      send_random(CMD_FINISH);
      repeat (4) send_random(CMD_SHIFT);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
